/* hdl/fsgs_pkg.sv */
package fsgs_pkg;

  localparam int GRID_W = 256;
  localparam int GRID_H = 256;

  localparam int XW = $clog2(GRID_W);
  localparam int YW = $clog2(GRID_H);

  localparam logic [15:0] SEED_RESET = 16'd44257;

  typedef logic [GRID_H-1:0] col_t;

  typedef enum logic [1:0] {
    ACT_PLACE = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_FRAME = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // Control from the sequencer to the column window.
  typedef struct packed {
    logic          clear;
    logic          shift;
    logic          shift_valid;
    logic          step;
    logic          has_left;
    logic          has_right;
    logic [YW-1:0] y;
  } scan_ctrl_t;

endpackage

/* hdl/fsgs_ram.sv */
module fsgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/fsgs_scan.sv */
module fsgs_scan
  import fsgs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [15:0] cfg_rng_seed,
  input  scan_ctrl_t ctrl,
  input  col_t       rd_data,
  output col_t       wb_col
);

  // Old columns x-1, x, x+1 and their next-frame images.
  col_t col_l_r, col_c_r, col_r_r;
  col_t nxt_l_r, nxt_c_r, nxt_r_r;
  col_t col_l_nxt, col_c_nxt, col_r_nxt;
  col_t nxt_l_nxt, nxt_c_nxt, nxt_r_nxt;
  logic [15:0] lfsr_r, lfsr_nxt;
  logic          fb;
  logic          left_free, right_free;
  logic [YW-1:0] y1;

  assign wb_col = nxt_l_r;
  assign y1 = ctrl.y + YW'(1);
  assign fb = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];
  assign left_free = ctrl.has_left && !col_l_r[y1];
  assign right_free = ctrl.has_right && !col_r_r[y1];

  always_comb begin
    col_l_nxt = col_l_r;
    col_c_nxt = col_c_r;
    col_r_nxt = col_r_r;
    nxt_l_nxt = nxt_l_r;
    nxt_c_nxt = nxt_c_r;
    nxt_r_nxt = nxt_r_r;
    lfsr_nxt  = lfsr_r;
    if (ctrl.clear) begin
      col_l_nxt = '0;
      col_c_nxt = '0;
      col_r_nxt = '0;
      nxt_l_nxt = '0;
      nxt_c_nxt = '0;
      nxt_r_nxt = '0;
    end else if (ctrl.shift) begin
      col_l_nxt = col_c_r;
      col_c_nxt = col_r_r;
      col_r_nxt = ctrl.shift_valid ? rd_data : '0;
      nxt_l_nxt = nxt_c_r;
      nxt_c_nxt = nxt_r_r;
      nxt_r_nxt = ctrl.shift_valid ? rd_data : '0;
    end else if (ctrl.step && col_c_r[ctrl.y]) begin
      // Targets are always empty in the old grid, so clearing a source and
      // setting a target never fight over one cell.
      priority if (!col_c_r[y1]) begin
        nxt_c_nxt[ctrl.y] = 1'b0;
        nxt_c_nxt[y1]     = 1'b1;
      end else if (left_free && right_free) begin
        lfsr_nxt = {fb, lfsr_r[15:1]};
        nxt_c_nxt[ctrl.y] = 1'b0;
        if (fb) begin
          nxt_r_nxt[y1] = 1'b1;
        end else begin
          nxt_l_nxt[y1] = 1'b1;
        end
      end else if (left_free) begin
        nxt_c_nxt[ctrl.y] = 1'b0;
        nxt_l_nxt[y1]     = 1'b1;
      end else if (right_free) begin
        nxt_c_nxt[ctrl.y] = 1'b0;
        nxt_r_nxt[y1]     = 1'b1;
      end else begin
        nxt_c_nxt = nxt_c_r;
      end
    end
    if (cfg_we) begin
      lfsr_nxt = cfg_rng_seed;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED_RESET;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
    col_l_r <= col_l_nxt;
    col_c_r <= col_c_nxt;
    col_r_r <= col_r_nxt;
    nxt_l_r <= nxt_l_nxt;
    nxt_c_r <= nxt_c_nxt;
    nxt_r_r <= nxt_r_nxt;
  end

endmodule

/* hdl/falling_sand_grid_step_unit.sv */
// Falling-sand grid stepper. The grid lives in one memory with one column
// (all rows of one x) per word. A command is taken when start is high and busy
// is low; its single result appears on out_cell_full for one cycle with
// out_strobe high and must be taken then, since the receiver cannot stall.
// Clear writes every column of the memory. During a frame the column window
// visits one cell per cycle and, after each column, writes back and fetches
// the memory and shifts the window. The result beat comes in the first cycle
// after busy falls.
// After reset, busy stays high while the memory is cleared.
// A seed write loads the random-bit LFSR at once.
module falling_sand_grid_step_unit
  import fsgs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_pos_x,
  input  logic [7:0]  in_pos_y,
  output logic        out_strobe,
  output logic        out_cell_full,
  input  logic        cfg_we,
  input  logic [15:0] cfg_rng_seed
);

  typedef enum logic [3:0] {
    S_RST_CLR,
    S_IDLE,
    S_CLR,
    S_PLACE,
    S_READ,
    S_F_INIT,
    S_F_PRE0,
    S_F_PRE1,
    S_F_SCAN,
    S_F_WR,
    S_F_SH,
    S_F_LAST
  } state_t;

  state_t        state_r, state_nxt;
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [XW-1:0] cmd_x_r, cmd_x_nxt;
  logic [YW-1:0] cmd_y_r, cmd_y_nxt;
  logic          cmd_in_r, cmd_in_nxt;
  logic          strobe_r, strobe_nxt;
  logic          full_r, full_nxt;

  logic          ram_we, ram_re;
  logic [XW-1:0] ram_waddr, ram_raddr;
  col_t          ram_wdata, rd_data, wb_col;
  scan_ctrl_t    ctrl;
  logic          accept;
  logic          pos_ok;
  logic          last_x;
  logic          has_far;

  assign busy          = (state_r != S_IDLE);
  assign out_strobe    = strobe_r;
  assign out_cell_full = full_r;
  assign accept        = start && !busy;
  assign pos_ok        = (32'(in_pos_x) < GRID_W) && (32'(in_pos_y) < GRID_H);
  assign last_x        = (x_r == XW'(GRID_W - 1));
  assign has_far       = (32'(x_r) + 32'd2 < GRID_W);

  always_comb begin
    state_nxt  = state_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    cmd_x_nxt  = cmd_x_r;
    cmd_y_nxt  = cmd_y_r;
    cmd_in_nxt = cmd_in_r;
    strobe_nxt = 1'b0;
    full_nxt   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = x_r;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = XW'(in_pos_x);
    ctrl       = '0;
    ctrl.y          = y_r;
    ctrl.has_left   = (x_r != '0);
    ctrl.has_right  = (32'(x_r) + 32'd1 < GRID_W);
    unique case (state_r)
      S_RST_CLR, S_CLR: begin
        ram_we = 1'b1;
        x_nxt  = x_r + XW'(1);
        if (last_x) begin
          x_nxt      = '0;
          state_nxt  = S_IDLE;
          strobe_nxt = (state_r == S_CLR);
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_x_nxt  = XW'(in_pos_x);
          cmd_y_nxt  = YW'(in_pos_y);
          cmd_in_nxt = pos_ok;
          x_nxt      = '0;
          y_nxt      = '0;
          unique case (action_t'(in_action))
            ACT_PLACE: begin
              ram_re    = 1'b1;
              state_nxt = S_PLACE;
            end
            ACT_READ: begin
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end
            ACT_CLEAR: state_nxt = S_CLR;
            ACT_FRAME: state_nxt = S_F_INIT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_PLACE: begin
        // The read was issued on acceptance; the modified column goes back now.
        ram_we     = cmd_in_r;
        ram_waddr  = cmd_x_r;
        ram_wdata  = rd_data | (col_t'(1) << cmd_y_r);
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_READ: begin
        full_nxt   = cmd_in_r && rd_data[cmd_y_r];
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_F_INIT: begin
        ctrl.clear = 1'b1;
        ram_re     = 1'b1;
        ram_raddr  = '0;
        state_nxt  = S_F_PRE0;
      end
      S_F_PRE0: begin
        ctrl.shift       = 1'b1;
        ctrl.shift_valid = 1'b1;
        ram_re           = 1'b1;
        ram_raddr        = XW'(1);
        state_nxt        = S_F_PRE1;
      end
      S_F_PRE1: begin
        ctrl.shift       = 1'b1;
        ctrl.shift_valid = 1'b1;
        state_nxt        = S_F_SCAN;
      end
      S_F_SCAN: begin
        ctrl.step = 1'b1;
        if (y_r == YW'(GRID_H - 2)) begin
          state_nxt = S_F_WR;
        end else begin
          y_nxt = y_r + YW'(1);
        end
      end
      S_F_WR: begin
        // Column x-1 is final once column x has been scanned; the write and the
        // fetch of column x+2 never touch the same word.
        ram_we    = (x_r != '0);
        ram_waddr = x_r - XW'(1);
        ram_wdata = wb_col;
        ram_re    = has_far;
        ram_raddr = x_r + XW'(2);
        state_nxt = S_F_SH;
      end
      S_F_SH: begin
        ctrl.shift       = 1'b1;
        ctrl.shift_valid = has_far;
        if (last_x) begin
          state_nxt = S_F_LAST;
        end else begin
          x_nxt     = x_r + XW'(1);
          y_nxt     = '0;
          state_nxt = S_F_SCAN;
        end
      end
      S_F_LAST: begin
        ram_we     = 1'b1;
        ram_waddr  = x_r;
        ram_wdata  = wb_col;
        strobe_nxt = 1'b1;
        x_nxt      = '0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_RST_CLR;
      x_r      <= '0;
      y_r      <= '0;
      strobe_r <= 1'b0;
      full_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      strobe_r <= strobe_nxt;
      full_r   <= full_nxt;
    end
    cmd_x_r  <= cmd_x_nxt;
    cmd_y_r  <= cmd_y_nxt;
    cmd_in_r <= cmd_in_nxt;
  end

  fsgs_ram #(
    .WIDTH(GRID_H),
    .DEPTH(GRID_W)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  fsgs_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_rng_seed (cfg_rng_seed),
    .ctrl         (ctrl),
    .rd_data      (rd_data),
    .wb_col       (wb_col)
  );

endmodule

/* hdl/fsgs_checker.sv */
module fsgs_checker
  import fsgs_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_action,
  input logic       out_strobe,
  input logic       out_cell_full
);

  // A result beat is shown only once the block has gone idle again.
  ast_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result beat while busy");

  // Every accepted command makes the block busy in the next cycle.
  ast_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // No command finishes straight from idle, so result beats never abut.
  ast_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result beats in a row");

  // A place command returns an empty cell with its result beat.
  ast_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_action == ACT_PLACE) |=> ##1 (out_strobe && !out_cell_full))
    else $error("place returned a full cell or came late");

endmodule

bind falling_sand_grid_step_unit fsgs_checker u_fsgs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_action     (in_action),
  .out_strobe    (out_strobe),
  .out_cell_full (out_cell_full)
);
